FILE: hdl/fbrle_pkg.sv
// ---------------------------------------------------------------------------
// fbrle_pkg: shared types and constants for the framed byte rle encoder
// result word layout, result bundle and configuration register indexes
// ---------------------------------------------------------------------------
package fbrle_pkg;

   // configuration register indexes
   localparam logic CSR_FRAME_SIZE  = 1'b0;
   localparam logic CSR_FRAME_LIMIT = 1'b1;

   localparam logic [15:0] FRAME_SIZE_RESET  = 16'd6144;
   localparam logic [23:0] FRAME_LIMIT_RESET = 24'hffffff;
   localparam logic [7:0]  RUN_MAX           = 8'hff;

   // result kinds
   localparam logic KIND_PAIR = 1'b0;
   localparam logic KIND_PAD  = 1'b1;

   typedef struct packed {
      logic       out_kind;
      logic [7:0] symbol;
      logic [7:0] run_length;
      logic [6:0] pad_pairs;
      logic       last_of_item;
   } result_type;

   // up to three results caused by one input word, packed from slot 0
   typedef struct packed {
      result_type [2:0] slot;
      logic [1:0]       count;
   } bundle_type;

endpackage

FILE: hdl/fbrle_core.sv
// ---------------------------------------------------------------------------
// fbrle_core: configuration, run and frame state, result bundle build
// one input word below the frame limit is folded into the state in its accept cycle
// ---------------------------------------------------------------------------
module fbrle_core #(
   parameter int PAD_ALIGN = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [23:0]            csr_wdata,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   output fbrle_pkg::bundle_type  bundle
);

   localparam int MW = $clog2(PAD_ALIGN);
   localparam int RW = MW + 2;
   localparam int PW = (RW > 8) ? RW : 8;
   localparam logic [MW:0]   PAD_S = (MW + 1)'(PAD_ALIGN);
   localparam logic [RW-1:0] PAD_R = RW'(PAD_ALIGN);

   logic [15:0]   frame_size_ff;
   logic [23:0]   frame_limit_ff;
   logic [7:0]    run_symbol_ff, run_symbol_in;
   logic [7:0]    run_count_ff, run_count_in;
   logic [15:0]   frame_position_ff, frame_position_in;
   logic [MW-1:0] frame_bytes_mod_ff, frame_bytes_mod_in;
   logic [23:0]   frames_done_ff, frames_done_in;

   logic          drop, start, frame_end, extend, flush;
   logic [16:0]   size_ext, pos_inc;
   logic [MW-1:0] mod_a, mod_b;
   logic [RW-1:0] rem_base, rem;
   logic [PW-1:0] pad_wide;
   fbrle_pkg::result_type flush_res, end_res, pad_res;

   // add two bytes modulo the pad alignment
   function automatic logic [MW-1:0] mod_add2(input logic [MW-1:0] m);
      logic [MW:0] s;
      s = {1'b0, m} + (MW + 1)'(2);
      if (s >= PAD_S) begin
         s = s - PAD_S;
      end
      return s[MW-1:0];
   endfunction

   always_comb begin
      // zero frame size means 65536
      size_ext  = {(frame_size_ff == 16'd0), frame_size_ff};
      pos_inc   = {1'b0, frame_position_ff} + 17'd1;
      drop      = frames_done_ff >= frame_limit_ff;
      start     = frame_position_ff == 16'd0;
      frame_end = pos_inc >= size_ext;
      extend    = !start && (data_byte == run_symbol_ff)
                  && (run_count_ff < fbrle_pkg::RUN_MAX);
      flush     = !start && !extend;

      run_symbol_in = extend ? run_symbol_ff : data_byte;
      run_count_in  = extend ? run_count_ff + 8'd1 : 8'd1;

      mod_a = flush ? mod_add2(frame_bytes_mod_ff) : frame_bytes_mod_ff;
      mod_b = mod_add2(mod_a);

      rem_base = (mod_b == '0) ? '0 : PAD_R - RW'(mod_b);
      rem      = rem_base[0] ? rem_base + PAD_R : rem_base;
      pad_wide = PW'(rem) >> 1;

      flush_res = '{out_kind: fbrle_pkg::KIND_PAIR, symbol: run_symbol_ff,
                    run_length: run_count_ff, pad_pairs: 7'd0,
                    last_of_item: !frame_end};
      end_res   = '{out_kind: fbrle_pkg::KIND_PAIR, symbol: run_symbol_in,
                    run_length: run_count_in, pad_pairs: 7'd0,
                    last_of_item: 1'b0};
      pad_res   = '{out_kind: fbrle_pkg::KIND_PAD, symbol: 8'd0,
                    run_length: 8'd0, pad_pairs: pad_wide[6:0],
                    last_of_item: 1'b1};

      bundle = '0;
      if (!drop) begin
         if (flush) begin
            bundle.slot[0] = flush_res;
            bundle.slot[1] = end_res;
            bundle.slot[2] = pad_res;
         end else begin
            bundle.slot[0] = end_res;
            bundle.slot[1] = pad_res;
            bundle.slot[2] = pad_res;
         end
         bundle.count = {frame_end, 1'b0} + {1'b0, flush};
      end

      frame_bytes_mod_in = frame_end ? '0 : mod_a;
      frame_position_in  = frame_end ? 16'd0 : pos_inc[15:0];
      frames_done_in     = frame_end ? frames_done_ff + 24'd1 : frames_done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff      <= fbrle_pkg::FRAME_SIZE_RESET;
         frame_limit_ff     <= fbrle_pkg::FRAME_LIMIT_RESET;
         run_symbol_ff      <= 8'd0;
         run_count_ff       <= 8'd0;
         frame_position_ff  <= 16'd0;
         frame_bytes_mod_ff <= '0;
         frames_done_ff     <= 24'd0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               fbrle_pkg::CSR_FRAME_SIZE:  frame_size_ff  <= csr_wdata[15:0];
               fbrle_pkg::CSR_FRAME_LIMIT: frame_limit_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (accept && !drop) begin
            run_symbol_ff      <= run_symbol_in;
            run_count_ff       <= run_count_in;
            frame_position_ff  <= frame_position_in;
            frame_bytes_mod_ff <= frame_bytes_mod_in;
            frames_done_ff     <= frames_done_in;
         end
      end
   end

endmodule

FILE: hdl/fbrle_out.sv
// ---------------------------------------------------------------------------
// fbrle_out: result register and serializer
// holds one bundle and hands its results out, while rsp_tready is high, one word per cycle
// ---------------------------------------------------------------------------
module fbrle_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  fbrle_pkg::bundle_type  bundle,
   output logic                   can_load,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output fbrle_pkg::result_type  result
);

   fbrle_pkg::result_type [2:0] slot_ff;
   logic [1:0] count_ff;
   logic [1:0] rd_idx_ff;
   logic       taken, last_taken;

   always_comb begin
      rsp_tvalid = rd_idx_ff != count_ff;
      taken      = rsp_tvalid && rsp_tready;
      last_taken = taken && (rd_idx_ff + 2'd1 == count_ff);
      can_load   = !rsp_tvalid || last_taken;
      unique case (rd_idx_ff)
         2'd0:    result = slot_ff[0];
         2'd1:    result = slot_ff[1];
         2'd2:    result = slot_ff[2];
         default: result = slot_ff[2];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         rd_idx_ff <= 2'd0;
      end else if (load) begin
         count_ff  <= bundle.count;
         rd_idx_ff <= 2'd0;
      end else if (taken) begin
         rd_idx_ff <= rd_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= bundle.slot;
      end
   end

endmodule

FILE: hdl/framed_byte_rle_encoder.sv
// ---------------------------------------------------------------------------
// framed_byte_rle_encoder: framed byte run-length encoder
// encodes a byte stream as (symbol, run) pairs with per-frame padding words
// ---------------------------------------------------------------------------
// usage
//   req_* carries one raw byte per word; rsp_* carries one result per word
//   csr_* writes frame_size (index 0) and frame_limit (index 1) while idle
//   a byte folds into the run and frame state in the cycle it is accepted;
//   its results sit in the result register from the next cycle
//   throughput: one byte per cycle while each byte gives at most one result
//   and rsp_tready is high; a frame end gives up to three results, streamed
//   one per cycle from the result register while rsp_tready is high; the input stalls there
//   a byte beyond the frame limit is taken with no result
//   reset clears the run, frame position, frame count and pending results,
//   and loads frame_size 6144 and frame_limit all ones
//   when rsp_tready is low the result holds and req_tready drops once the
//   pending results cannot be handed over this cycle
// ---------------------------------------------------------------------------
module framed_byte_rle_encoder #(
   parameter int PAD_ALIGN = 256
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] symbol, [15:8] run_length, [22:16] pad_pairs
   output logic        rsp_tuser,   // [0] out_kind
   output logic        rsp_tlast,   // last result of the input word
   // configuration writes
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [23:0] csr_wdata
);

   fbrle_pkg::bundle_type bundle;
   fbrle_pkg::result_type result;
   logic can_load, accept;

   // a word is taken whenever the result register frees up this cycle
   assign req_tready = can_load;
   assign accept     = req_tvalid && req_tready;

   fbrle_core #(
      .PAD_ALIGN (PAD_ALIGN)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .data_byte (req_tdata),
      .bundle    (bundle)
   );

   fbrle_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .bundle     (bundle),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .result     (result)
   );

   // pack the result word, zero fill to whole bytes
   assign rsp_tdata = {1'b0, result.pad_pairs, result.run_length, result.symbol};
   assign rsp_tuser = result.out_kind;
   assign rsp_tlast = result.last_of_item;

endmodule
